FILE: rtl/bgea_pkg.sv
package bgea_pkg;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_ACC  = 2'd1;
    localparam logic [1:0] CMD_CLR  = 2'd2;

    localparam logic [1:0] CODE_MISSING = 2'd1;

    localparam int DIV_BITS  = 26;
    localparam int MOD_STEPS = 2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         byte_index;
        logic [7:0]         record_byte;
        logic [12:0]        row;
        logic [11:0]        slot;
        logic [15:0]        replacement;
        logic [15:0]        center;
        logic [15:0]        scale;
        logic signed [15:0] effect_0;
        logic signed [15:0] effect_1;
        logic signed [15:0] effect_2;
        logic signed [15:0] effect_3;
    } t_in;

    typedef struct packed {
        logic signed [47:0] sum_0;
        logic signed [47:0] sum_1;
        logic signed [47:0] sum_2;
        logic signed [47:0] sum_3;
        logic               was_missing;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic       cap;
        logic       mod_step;
        logic       rec_rd;
        logic       div_load;
        logic       div_step;
        logic       fix;
        logic       load_wr;
        logic       sum_rd;
        logic       mul;
        logic       acc;
        logic       clr_wr;
        logic       fin;
        logic [4:0] cnt;
        logic [1:0] k;
    } t_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       out_busy;
    } t_stat;

    function automatic logic [15:0] geno_raw(input logic [1:0] code,
                                             input logic [15:0] repl);
        logic [15:0] v;
        case (code)
            2'd0:    v = 16'd32768;
            2'd2:    v = 16'd16384;
            2'd3:    v = 16'd0;
            default: v = repl;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/bed_genotype_effect_accumulate.sv
// An accumulate steps through a record read, the 26-step bit-serial divider and a per-trait
// read, multiply and accumulate over MAX_TRAITS; a slot clear writes one trait of MAX_TRAITS
// per step, a load writes one record byte, and a no-op goes straight to the finish. One item
// is in work at a time, and the next transfer is taken at the edge where the result can
// leave; the output register holds a stalled result.
// Reset clears the controller, the output valid and sets r_traits to 1; the record
// and sum memories are not cleared.
module bed_genotype_effect_accumulate
    import bgea_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int MAX_TRAITS  = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    bgea_ctrl #(
        .MAX_TRAITS(MAX_TRAITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    bgea_dp #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .MAX_TRAITS (MAX_TRAITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd      (w_cmd),
        .i_out_stall(i_out_stall),
        .o_stat     (w_stat),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

endmodule

FILE: rtl/bgea_ctrl.sv
module bgea_ctrl
    import bgea_pkg::*;
#(
    parameter int MAX_TRAITS = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_CLR   = 4'd3;
    localparam logic [3:0] S_REC   = 4'd4;
    localparam logic [3:0] S_DLOAD = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FIX   = 4'd7;
    localparam logic [3:0] S_TRD   = 4'd8;
    localparam logic [3:0] S_TMUL  = 4'd9;
    localparam logic [3:0] S_TACC  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    localparam logic [1:0] K_LAST = 2'(MAX_TRAITS - 1);

    logic [3:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.cnt = r_cnt;
        o_cmd.k   = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_cnt     = 5'(MOD_STEPS - 1);
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_cnt          = r_cnt - 5'd1;
                n_k            = '0;
                if (r_cnt == '0) begin
                    case (i_stat.cmd)
                        CMD_LOAD: n_state = S_LOAD;
                        CMD_CLR:  n_state = S_CLR;
                        CMD_ACC:  n_state = S_REC;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state       = S_FIN;
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                n_k          = r_k + 2'd1;
                if (r_k == K_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_REC: begin
                o_cmd.rec_rd = 1'b1;
                n_state      = S_DLOAD;
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = 5'(DIV_BITS - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_k       = '0;
                n_state   = S_TRD;
            end
            S_TRD: begin
                o_cmd.sum_rd = 1'b1;
                n_state      = S_TMUL;
            end
            S_TMUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_TACC;
            end
            S_TACC: begin
                o_cmd.acc = 1'b1;
                n_k       = r_k + 2'd1;
                n_state   = (r_k == K_LAST) ? S_FIN : S_TRD;
            end
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/bgea_dp.sv
module bgea_dp
    import bgea_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int MAX_TRAITS  = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in        i_in_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    input  t_cmd       i_cmd,
    input  logic       i_out_stall,
    output t_stat      o_stat,
    output logic       o_out_valid,
    output t_out       o_out_data
);

    localparam int RB    = (MAX_SAMPLES + 3) / 4;
    localparam int RAW_W = (RB > 1) ? $clog2(RB) : 1;
    localparam int SDEP  = MAX_SAMPLES * MAX_TRAITS;
    localparam int SA_W  = $clog2(SDEP);
    localparam int RSH   = 13 + $clog2(MAX_SAMPLES);
    localparam logic [15:0] RCP =
        16'(((64'd1 << RSH) + 64'(MAX_SAMPLES) - 64'd1) / 64'(MAX_SAMPLES));
    localparam logic signed [23:0] T_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] T_MIN = 24'sh800000;
    localparam logic signed [47:0] S_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] S_MIN = {1'b1, {47{1'b0}}};

    logic [7:0]         r_rec_mem [RB];
    logic signed [47:0] r_sum_mem [SDEP];

    t_in                r_in;
    logic [2:0]         r_traits;
    logic [12:0]        r_idx;
    logic [12:0]        r_slot;
    logic [12:0]        r_qi;
    logic [12:0]        r_qs;
    logic [7:0]         r_rec_q;
    logic signed [47:0] r_sum_q;
    logic               r_neg;
    logic               r_zero;
    logic [15:0]        r_rem;
    logic [25:0]        r_q;
    logic signed [23:0] r_t;
    logic signed [39:0] r_prod;
    logic signed [47:0] r_sums [4];
    logic               r_miss;
    logic               r_sat;
    logic               r_out_valid;
    t_out               r_out;

    logic [31:0]        w_idx_p;
    logic [31:0]        w_slot_p;
    logic [31:0]        w_idx_m;
    logic [31:0]        w_slot_m;
    logic [SA_W-1:0]    w_saddr;
    logic [1:0]         w_code;
    logic [15:0]        w_raw;
    logic signed [16:0] w_diff;
    logic [16:0]        w_rsh;
    logic               w_ge;
    logic signed [15:0] w_eff;
    logic signed [48:0] w_acc;
    logic signed [47:0] w_accs;
    logic               w_accsat;
    logic [2:0]         w_active;
    logic               w_kact;

    // Row and slot are reduced by multiplying with the rounded-up reciprocal of the
    // sample count, which gives the exact quotient for every 13-bit value.
    assign w_idx_p  = 32'(r_idx) * 32'(RCP);
    assign w_slot_p = 32'(r_slot) * 32'(RCP);
    assign w_idx_m  = 32'(r_qi) * 32'(MAX_SAMPLES);
    assign w_slot_m = 32'(r_qs) * 32'(MAX_SAMPLES);
    assign w_saddr  = SA_W'(32'(r_slot) * 32'(MAX_TRAITS) + 32'(i_cmd.k));
    assign w_code   = 2'(r_rec_q >> {r_idx[1:0], 1'b0});
    assign w_raw    = geno_raw(w_code, r_in.replacement);
    assign w_diff   = $signed({1'b0, w_raw}) - $signed({1'b0, r_in.center});
    assign w_rsh    = {r_rem, r_q[25]};
    assign w_ge     = (w_rsh >= {1'b0, r_in.scale});
    assign w_active = (r_traits > 3'(MAX_TRAITS)) ? 3'(MAX_TRAITS) : r_traits;
    assign w_kact   = ({1'b0, i_cmd.k} < w_active);

    always_comb begin
        case (i_cmd.k)
            2'd0:    w_eff = r_in.effect_0;
            2'd1:    w_eff = r_in.effect_1;
            2'd2:    w_eff = r_in.effect_2;
            default: w_eff = r_in.effect_3;
        endcase
    end

    assign w_acc = 49'(r_sum_q) + 49'(r_prod);
    always_comb begin
        w_accsat = 1'b0;
        w_accs   = r_sum_q;
        if (w_acc > 49'(S_MAX)) begin
            w_accs   = S_MAX;
            w_accsat = 1'b1;
        end else if (w_acc < 49'(S_MIN)) begin
            w_accs   = S_MIN;
            w_accsat = 1'b1;
        end else begin
            w_accs = 48'(w_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && ({22'd0, r_in.byte_index} < 32'(RB))) begin
            r_rec_mem[RAW_W'(r_in.byte_index)] <= r_in.record_byte;
        end
        if (i_cmd.rec_rd) begin
            r_rec_q <= r_rec_mem[RAW_W'(r_idx >> 2)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_sum_mem[w_saddr] <= '0;
        end else if (i_cmd.acc && w_kact) begin
            r_sum_mem[w_saddr] <= w_accs;
        end
        if (i_cmd.sum_rd) begin
            r_sum_q <= r_sum_mem[w_saddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_in   <= i_in_data;
            r_idx  <= i_in_data.row - 13'd1;
            r_slot <= {1'b0, i_in_data.slot};
            r_miss <= 1'b0;
            r_sat  <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_sums[i] <= '0;
            end
        end
        if (i_cmd.mod_step) begin
            if (i_cmd.cnt != '0) begin
                r_qi <= 13'(w_idx_p >> RSH);
                r_qs <= 13'(w_slot_p >> RSH);
            end else begin
                r_idx  <= r_idx - 13'(w_idx_m);
                r_slot <= r_slot - 13'(w_slot_m);
            end
        end
        if (i_cmd.div_load) begin
            r_miss <= (w_code == CODE_MISSING);
            r_neg  <= w_diff[16];
            r_zero <= (w_diff == '0);
            r_q    <= {(w_diff[16] ? 16'(-w_diff) : 16'(w_diff)), 10'd0};
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? 16'(w_rsh - {1'b0, r_in.scale}) : w_rsh[15:0];
            r_q   <= {r_q[24:0], w_ge};
        end
        if (i_cmd.fix) begin
            if (r_in.scale == '0) begin
                r_sat <= 1'b1;
                r_t   <= r_zero ? 24'sd0 : (r_neg ? T_MIN : T_MAX);
            end else if (r_neg) begin
                if (r_q > 26'h800000) begin
                    r_t   <= T_MIN;
                    r_sat <= 1'b1;
                end else begin
                    r_t <= 24'(-r_q);
                end
            end else if (r_q > 26'h7FFFFF) begin
                r_t   <= T_MAX;
                r_sat <= 1'b1;
            end else begin
                r_t <= 24'(r_q);
            end
        end
        if (i_cmd.mul) begin
            r_prod <= r_t * w_eff;
        end
        if (i_cmd.acc) begin
            if (w_kact) begin
                r_sums[i_cmd.k] <= w_accs;
                if (w_accsat) begin
                    r_sat <= 1'b1;
                end
            end else begin
                r_sums[i_cmd.k] <= r_sum_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_traits    <= 3'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_traits <= i_cfg_wdata;
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out.sum_0       <= r_sums[0];
            r_out.sum_1       <= r_sums[1];
            r_out.sum_2       <= r_sums[2];
            r_out.sum_3       <= r_sums[3];
            r_out.was_missing <= (r_in.cmd == CMD_ACC) && r_miss;
            r_out.saturated   <= (r_in.cmd == CMD_ACC) && r_sat;
        end
    end

    assign o_stat.cmd      = r_in.cmd;
    assign o_stat.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

FILE: tb/bed_genotype_effect_accumulate_tb.sv
module bed_genotype_effect_accumulate_tb;
    import bgea_pkg::*;

    localparam int SAMPLES = 4096;
    localparam int TRAITS = 4;
    localparam int IN_W = $bits(t_in);
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam longint T_HI = 64'sd8388607;
    localparam longint T_LO = -64'sd8388608;
    localparam longint S_HI = 64'sd140737488355327;
    localparam longint S_LO = -64'sd140737488355328;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       o_in_stall;
    t_in        in_data = '0;
    logic       o_out_valid;
    logic       out_stall = 1'b0;
    t_out       o_out_data;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_wdata = 3'd1;

    bed_genotype_effect_accumulate #(
        .MAX_SAMPLES(SAMPLES),
        .MAX_TRAITS (TRAITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in    send_queue[$];
    t_out   expected_sums[$];
    logic [7:0] genotype_bytes[0:1023];
    bit     byte_loaded[0:1023];
    bit     slot_cleared[0:SAMPLES-1];
    longint slot_sums[0:SAMPLES*TRAITS-1];
    logic [2:0] traits_reg = 3'd1;
    int     errors = 0;
    int     gap = 0;
    int     hold = 0;
    bit     no_idle = 1'b0;
    int     n_acc = 0;
    int     n_sat = 0;
    int     n_missing = 0;

    function automatic t_out accumulate_genotype(t_in x);
        t_out   r;
        int     sl;
        int     idx;
        logic [1:0] code;
        longint raw;
        longint diff;
        longint t;
        longint s;
        longint eff[4];
        longint outv[4];
        int     active;
        logic   sat;
        r = '0;
        sl = int'(x.slot) % SAMPLES;
        eff[0] = {{48{x.effect_0[15]}}, x.effect_0};
        eff[1] = {{48{x.effect_1[15]}}, x.effect_1};
        eff[2] = {{48{x.effect_2[15]}}, x.effect_2};
        eff[3] = {{48{x.effect_3[15]}}, x.effect_3};
        for (int k = 0; k < 4; k++) outv[k] = 0;
        sat = 1'b0;
        case (x.cmd)
            CMD_LOAD: begin
                genotype_bytes[x.byte_index] = x.record_byte;
                byte_loaded[x.byte_index] = 1'b1;
            end
            CMD_CLR: begin
                for (int k = 0; k < TRAITS; k++) slot_sums[sl*TRAITS+k] = 0;
                slot_cleared[sl] = 1'b1;
            end
            CMD_ACC: begin
                idx = int'(13'(x.row - 13'd1)) % SAMPLES;
                code = 2'(genotype_bytes[idx/4] >> (2 * (idx % 4)));
                case (code)
                    2'd0: raw = 32768;
                    2'd2: raw = 16384;
                    2'd3: raw = 0;
                    default: raw = x.replacement;
                endcase
                r.was_missing = (code == CODE_MISSING);
                diff = raw - longint'(x.center);
                if (x.scale == 16'd0) begin
                    sat = 1'b1;
                    t = diff > 0 ? T_HI : (diff < 0 ? T_LO : 0);
                end else begin
                    t = (diff * 1024) / longint'(x.scale);
                    if (t > T_HI) begin
                        t = T_HI;
                        sat = 1'b1;
                    end
                    if (t < T_LO) begin
                        t = T_LO;
                        sat = 1'b1;
                    end
                end
                active = traits_reg > TRAITS ? TRAITS : traits_reg;
                for (int k = 0; k < active; k++) begin
                    s = slot_sums[sl*TRAITS+k] + t * eff[k];
                    if (s > S_HI) begin
                        s = S_HI;
                        sat = 1'b1;
                    end
                    if (s < S_LO) begin
                        s = S_LO;
                        sat = 1'b1;
                    end
                    slot_sums[sl*TRAITS+k] = s;
                end
                r.saturated = sat;
            end
            default: begin
            end
        endcase
        if (x.cmd == CMD_ACC || x.cmd == CMD_CLR) begin
            for (int k = 0; k < TRAITS; k++) outv[k] = slot_sums[sl*TRAITS+k];
            r.sum_0 = outv[0][47:0];
            r.sum_1 = outv[1][47:0];
            r.sum_2 = outv[2][47:0];
            r.sum_3 = outv[3][47:0];
        end
        return r;
    endfunction

    task automatic queue_item(t_in x);
        expected_sums.push_back(accumulate_genotype(x));
        send_queue.push_back(x);
    endtask

    // Accumulates only touch loaded bytes and cleared slots; missing ones are set up first.
    task automatic queue_safe(t_in x);
        t_in p;
        int  idx;
        if (x.cmd == CMD_ACC) begin
            idx = int'(13'(x.row - 13'd1)) % SAMPLES;
            if (!byte_loaded[idx/4]) begin
                p = x;
                p.cmd = CMD_LOAD;
                p.byte_index = 10'(idx / 4);
                p.record_byte = 8'($urandom);
                queue_item(p);
            end
            if (!slot_cleared[int'(x.slot)]) begin
                p = x;
                p.cmd = CMD_CLR;
                queue_item(p);
            end
        end
        queue_item(x);
    endtask

    function automatic t_in random_item();
        t_in x;
        int  w;
        x = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w = $urandom_range(0, 99);
        x.cmd = w < 60 ? CMD_ACC : (w < 80 ? CMD_LOAD : (w < 96 ? CMD_CLR : CMD_NOP));
        if ($urandom_range(0, 3) != 0) x.slot = 12'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0) x.scale = 16'd0;
        else if ($urandom_range(0, 5) == 0) x.scale = 16'($urandom_range(1, 64));
        if ($urandom_range(0, 3) == 0) x.center = 16'($urandom_range(0, 32768));
        return x;
    endfunction

    task automatic write_traits(logic [2:0] v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        traits_reg = v;
    endtask

    task automatic drain();
        while (send_queue.size() != 0 || expected_sums.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap = 0;
        end else if (in_valid && !o_in_stall) begin
            void'(send_queue.pop_front());
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (send_queue.size() != 0 && gap == 0) begin
                in_data <= send_queue[0];
            end else begin
                in_valid <= 1'b0;
            end
        end else if (!in_valid) begin
            if (gap > 0) begin
                gap = gap - 1;
            end else if (send_queue.size() != 0) begin
                in_valid <= 1'b1;
                in_data <= send_queue[0];
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (expected_sums.size() == 0) begin
                    report("unexpected transfer", 0, 0);
                end else begin
                    want = expected_sums.pop_front();
                    if (o_out_data.sum_0 !== want.sum_0) report("sum_0", o_out_data.sum_0, want.sum_0);
                    if (o_out_data.sum_1 !== want.sum_1) report("sum_1", o_out_data.sum_1, want.sum_1);
                    if (o_out_data.sum_2 !== want.sum_2) report("sum_2", o_out_data.sum_2, want.sum_2);
                    if (o_out_data.sum_3 !== want.sum_3) report("sum_3", o_out_data.sum_3, want.sum_3);
                    if (o_out_data.was_missing !== want.was_missing)
                        report("was_missing", o_out_data.was_missing, want.was_missing);
                    if (o_out_data.saturated !== want.saturated)
                        report("saturated", o_out_data.saturated, want.saturated);
                    n_sat += want.saturated;
                    n_missing += want.was_missing;
                end
                hold = no_idle ? 0 : $urandom_range(0, 5);
                out_stall <= (hold != 0);
            end else if (out_stall) begin
                hold = hold - 1;
                if (hold <= 0) out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_in x;
        logic [2:0] settings[6];
        settings = '{3'd0, 3'd2, 3'd3, 3'd7, 3'd5, 3'd4};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_traits(3'd4);
        x = '0;
        x.cmd = CMD_LOAD;
        x.byte_index = 10'd0;
        x.record_byte = 8'b11_10_01_00;
        queue_item(x);
        x.byte_index = 10'd1023;
        x.record_byte = 8'b01_00_11_10;
        queue_item(x);
        x.cmd = CMD_CLR;
        x.slot = 12'd0;
        queue_item(x);
        x.slot = 12'd4095;
        queue_item(x);
        x = '0;
        x.cmd = CMD_ACC;
        x.effect_0 = 16'sh7fff;
        x.effect_1 = 16'sh8000;
        x.effect_2 = 16'sh1000;
        x.effect_3 = -16'sd1;
        x.scale = 16'h1000;
        for (int r = 1; r <= 4; r++) begin
            x.row = 13'(r);
            x.replacement = 16'd32768;
            queue_item(x);
        end
        x.slot = 12'd4095;
        x.row = 13'd0;
        x.scale = 16'd0;
        queue_item(x);
        x.row = 13'd4096;
        x.center = 16'd32768;
        queue_item(x);
        x.row = 13'd8191;
        x.center = 16'd16384;
        queue_item(x);
        x.row = 13'd2;
        x.replacement = 16'hffff;
        x.center = 16'd0;
        x.scale = 16'd1;
        queue_item(x);
        x.scale = 16'hffff;
        x.effect_0 = 16'sh8000;
        queue_item(x);
        x.cmd = CMD_NOP;
        x.slot = 12'd0;
        queue_item(x);
        x = '1;
        x.cmd = CMD_CLR;
        queue_item(x);
        x.cmd = CMD_NOP;
        queue_item(x);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_traits(settings[ph]);
            repeat (12) queue_safe(random_item());
            drain();
        end

        // Drive all four traits of one slot into the sum limits, two in each direction.
        no_idle = 1'b1;
        x = '0;
        x.cmd = CMD_LOAD;
        x.byte_index = 10'd0;
        x.record_byte = 8'd0;
        queue_item(x);
        x.cmd = CMD_CLR;
        x.slot = 12'd7;
        queue_item(x);
        x.cmd = CMD_ACC;
        x.row = 13'd1;
        x.effect_0 = 16'sh7fff;
        x.effect_1 = 16'sh8000;
        x.effect_2 = 16'sh7fff;
        x.effect_3 = 16'sh8000;
        repeat (520) queue_item(x);
        drain();
        no_idle = 1'b0;

        $display("covered %0d results, %0d saturated, %0d with a missing genotype",
                 n_acc, n_sat, n_missing);
        $display("several trait settings between 0 and 7 applied, random and limit accumulates sent");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !out_stall) n_acc <= n_acc + 1;
    end

endmodule
